[src/dlms_pkg.sv]
// Package for the DFA longest-match scanner: transaction payload types,
// function codes and the pipeline stage kind codes.
// No dependencies.
package dlms_pkg;

    // Width of a transition entry: 0 no transition, else next state plus one
    localparam int ENTRY_BITS = 7;

    localparam logic [2:0] FUNC_WR_TRANS  = 3'd0;
    localparam logic [2:0] FUNC_WR_ACCEPT = 3'd1;
    localparam logic [2:0] FUNC_WR_FINAL  = 3'd2;
    localparam logic [2:0] FUNC_CHAR      = 3'd3;
    localparam logic [2:0] FUNC_END       = 3'd4;

    // Second stage: what the item in the transition read stage is
    localparam logic [1:0] K1_NONE = 2'd0;
    localparam logic [1:0] K1_CHAR = 2'd1;
    localparam logic [1:0] K1_END  = 2'd2;

    // Third stage: what the item in the accept read stage does
    localparam logic [2:0] K2_NONE  = 3'd0;
    localparam logic [2:0] K2_ADV   = 3'd1;
    localparam logic [2:0] K2_DEAD  = 3'd2;
    localparam logic [2:0] K2_END   = 3'd3;
    localparam logic [2:0] K2_QUIET = 3'd4;

    typedef struct packed {
        logic [2:0]            func;
        logic [5:0]            row_state;
        logic [6:0]            char_code;
        logic [ENTRY_BITS-1:0] next_entry;
        logic [5:0]            col_state;
        logic [15:0]           token_value;
        logic                  final_flag;
    } t_in_item;

    typedef struct packed {
        logic        longest_found;
        logic [15:0] token_length;
        logic [15:0] match_id;
        logic        full_match;
        logic        dead_end;
    } t_res_item;

    typedef struct packed {
        logic [2:0] kind;
        logic       full;
    } t_p2_ctrl;

endpackage

[src/dlms_chan_if.sv]
// Valid/ready channel interface carrying one payload per transaction.
// No dependencies; the payload type is supplied by the instantiating module.
interface dlms_chan_if #(parameter type t_payload = logic) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/dfa_longest_match_scanner_core.sv]
// DFA longest-match scanner top level: transition, accept and final-flag RAMs
// with a three-stage read pipeline. Depends on dlms_pkg, dlms_chan_if,
// dlms_ram and dlms_match_track.
// Throughput: one transaction per cycle, characters included, unless the result output
// stalls; the next state feeds straight from the transition RAM read data into its
// read address. A transaction passes the second-stage and third-stage registers before
// the output register presents its result. Reset: synchronous; a clearing pass zeroes
// all RAMs, input not ready meanwhile.
module dfa_longest_match_scanner_core
    import dlms_pkg::*;
#(
    parameter int STATES      = 64,
    parameter int ALPHABET    = 128,
    parameter int TOKEN_BITS  = 16,
    parameter int LENGTH_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dlms_chan_if.sink   i_in,
    dlms_chan_if.source o_res
);
    localparam int SW       = $clog2(STATES);
    localparam int CW       = $clog2(ALPHABET);
    localparam int TAW      = SW + CW;
    localparam int AAW      = 2 * SW;
    localparam int CLRW     = (TAW > AAW) ? TAW : AAW;
    localparam int TR_DEPTH = 1 << TAW;
    localparam int AC_DEPTH = 1 << AAW;
    localparam int FN_DEPTH = 1 << SW;
    localparam logic [LENGTH_BITS-1:0] LEN_MAX = '1;

    // ---------------------------------------------------------------------
    // Clearing pass after reset: sweep every RAM address at least once, writing zero
    // ---------------------------------------------------------------------
    logic            r_clr_busy;
    logic [CLRW-1:0] r_clr_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clr_busy) begin
            r_clr_cnt <= r_clr_cnt + 1'b1;
            if (r_clr_cnt == '1) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // First stage: transaction accepted, RAM addresses issued
    // ---------------------------------------------------------------------
    logic     advance;
    logic     acc;
    t_in_item it;
    logic     row_ok, ch_ok, col_ok;
    logic [SW-1:0] row_idx, col_idx;
    logic [CW-1:0] ch_idx;

    assign i_in.ready = advance && !r_clr_busy;
    assign acc        = i_in.valid && i_in.ready;
    assign it         = i_in.data;

    assign row_ok  = 32'(it.row_state) < 32'(STATES);
    assign col_ok  = 32'(it.col_state) < 32'(STATES);
    assign ch_ok   = 32'(it.char_code) < 32'(ALPHABET);
    assign row_idx = SW'(it.row_state);
    assign col_idx = SW'(it.col_state);
    assign ch_idx  = CW'(it.char_code);

    // Second-stage registers and the committed scan state (as seen after
    // every transaction that has left the second stage)
    logic [1:0]             r_s1_kind;
    logic                   r_s1_forced;
    logic                   r_s1_quiet;
    logic [SW-1:0]          r_s1_src;
    logic [SW-1:0]          r_state;
    logic                   r_stopped;
    logic [LENGTH_BITS-1:0] r_pos;

    logic [ENTRY_BITS-1:0]  tr_q;
    logic                   fn_q;
    logic [TOKEN_BITS-1:0]  ac_q;
    logic                   p1_dead;
    logic [SW-1:0]          p1_target;
    logic [LENGTH_BITS-1:0] p1_pos_inc;

    logic [SW-1:0]          n_state;
    logic                   n_stopped;
    logic [LENGTH_BITS-1:0] n_pos;

    assign p1_dead    = r_s1_forced || (tr_q == '0) || (32'(tr_q) > 32'(STATES));
    assign p1_target  = SW'(tr_q - ENTRY_BITS'(1));
    assign p1_pos_inc = (r_pos == LEN_MAX) ? r_pos : r_pos + 1'b1;

    // Forward the outcome of the character in the second stage, so that the
    // next character addresses the RAM with the state it has just produced
    always_comb begin
        n_state   = r_state;
        n_stopped = r_stopped;
        n_pos     = r_pos;
        unique case (r_s1_kind)
            K1_CHAR: begin
                if (p1_dead) begin
                    n_stopped = 1'b1;
                end else begin
                    n_state = p1_target;
                    n_pos   = p1_pos_inc;
                end
            end
            K1_END: begin
                n_state   = '0;
                n_stopped = 1'b0;
                n_pos     = '0;
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // RAMs: writes land at accept, or zeros during the clearing pass
    // ---------------------------------------------------------------------
    logic                  tr_we, ac_we, fn_we;
    logic [TAW-1:0]        tr_waddr;
    logic [AAW-1:0]        ac_waddr;
    logic [SW-1:0]         fn_waddr;
    logic [ENTRY_BITS-1:0] tr_wdata;
    logic [TOKEN_BITS-1:0] ac_wdata;
    logic                  fn_wdata;

    assign tr_we    = r_clr_busy || (acc && it.func == FUNC_WR_TRANS && row_ok && ch_ok);
    assign tr_waddr = r_clr_busy ? r_clr_cnt[TAW-1:0] : {row_idx, ch_idx};
    assign tr_wdata = r_clr_busy ? '0 : it.next_entry;

    assign ac_we    = r_clr_busy || (acc && it.func == FUNC_WR_ACCEPT && row_ok && col_ok);
    assign ac_waddr = r_clr_busy ? r_clr_cnt[AAW-1:0] : {row_idx, col_idx};
    assign ac_wdata = r_clr_busy ? '0 : TOKEN_BITS'(it.token_value);

    assign fn_we    = r_clr_busy || (acc && it.func == FUNC_WR_FINAL && row_ok);
    assign fn_waddr = r_clr_busy ? r_clr_cnt[SW-1:0] : row_idx;
    assign fn_wdata = r_clr_busy ? 1'b0 : it.final_flag;

    dlms_ram #(.WIDTH(ENTRY_BITS), .DEPTH(TR_DEPTH)) u_trans_ram (
        .i_clk   (i_clk),
        .i_we    (tr_we),
        .i_waddr (tr_waddr),
        .i_wdata (tr_wdata),
        .i_re    (advance),
        .i_raddr ({n_state, ch_idx}),
        .o_rdata (tr_q)
    );

    dlms_ram #(.WIDTH(1), .DEPTH(FN_DEPTH)) u_final_ram (
        .i_clk   (i_clk),
        .i_we    (fn_we),
        .i_waddr (fn_waddr),
        .i_wdata (fn_wdata),
        .i_re    (advance),
        .i_raddr (n_state),
        .o_rdata (fn_q)
    );

    // Read-first behaviour keeps an accept write that follows a character
    // from reaching that character's lookup
    dlms_ram #(.WIDTH(TOKEN_BITS), .DEPTH(AC_DEPTH)) u_accept_ram (
        .i_clk   (i_clk),
        .i_we    (ac_we),
        .i_waddr (ac_waddr),
        .i_wdata (ac_wdata),
        .i_re    (advance),
        .i_raddr ({r_s1_src, p1_target}),
        .o_rdata (ac_q)
    );

    // ---------------------------------------------------------------------
    // Stage advance: drop characters after a dead end, commit scan state
    // ---------------------------------------------------------------------
    logic [2:0]             r_s2_kind;
    logic                   r_s2_full;
    logic [LENGTH_BITS-1:0] r_s2_pos;
    t_p2_ctrl               s2_ctrl;

    assign s2_ctrl = {r_s2_kind, r_s2_full};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_kind <= K1_NONE;
            r_state   <= '0;
            r_stopped <= 1'b0;
            r_pos     <= '0;
            r_s2_kind <= K2_NONE;
        end else if (advance) begin
            r_state   <= n_state;
            r_stopped <= n_stopped;
            r_pos     <= n_pos;

            priority if (acc && it.func == FUNC_CHAR && !n_stopped) begin
                r_s1_kind <= K1_CHAR;
            end else if (acc && it.func == FUNC_END) begin
                r_s1_kind <= K1_END;
            end else begin
                r_s1_kind <= K1_NONE;
            end

            unique case (r_s1_kind)
                K1_CHAR: r_s2_kind <= p1_dead ? K2_DEAD : K2_ADV;
                K1_END:  r_s2_kind <= r_s1_quiet ? K2_QUIET : K2_END;
                default: r_s2_kind <= K2_NONE;
            endcase
        end
    end

    // Payload of the pipeline stages: no reset
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_s1_forced <= !ch_ok;
            r_s1_quiet  <= n_stopped;
            r_s1_src    <= n_state;
            r_s2_full   <= fn_q;
            r_s2_pos    <= p1_pos_inc;
        end
    end

    // ---------------------------------------------------------------------
    // Third stage and output register
    // ---------------------------------------------------------------------
    dlms_match_track #(
        .TOKEN_BITS  (TOKEN_BITS),
        .LENGTH_BITS (LENGTH_BITS)
    ) u_match_track (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctrl    (s2_ctrl),
        .i_pos     (r_s2_pos),
        .i_acc     (ac_q),
        .o_advance (advance),
        .o_res     (o_res)
    );

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !i_in.ready)
        else $error("input accepted during RAM clearing pass");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && !o_res.ready) |-> !i_in.ready)
        else $error("input accepted while result stalled");

    a_dead_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> !(o_res.data.full_match && o_res.data.dead_end))
        else $error("dead-end result flagged as full match");

    a_dead_stops_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && r_s1_kind == K1_CHAR && p1_dead) |=> r_stopped)
        else $error("dead transition did not stop the scan");

endmodule

[src/dlms_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module dlms_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read-first: a same-cycle write to the read address returns old data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

[src/dlms_match_track.sv]
// Last pipeline stage: longest-match bookkeeping and the result output register.
// Depends on dlms_pkg and dlms_chan_if.
module dlms_match_track
    import dlms_pkg::*;
#(
    parameter int TOKEN_BITS  = 16,
    parameter int LENGTH_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_p2_ctrl               i_ctrl,
    input  logic [LENGTH_BITS-1:0] i_pos,
    input  logic [TOKEN_BITS-1:0]  i_acc,
    output logic                   o_advance,
    dlms_chan_if.source            o_res
);
    logic                   r_match;
    logic [LENGTH_BITS-1:0] r_len;
    logic [TOKEN_BITS-1:0]  r_tok;
    logic                   r_valid;
    t_res_item              r_data;
    logic                   is_result;

    assign o_advance = !r_valid || o_res.ready;
    assign is_result = (i_ctrl.kind == K2_DEAD) || (i_ctrl.kind == K2_END);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match <= 1'b0;
            r_len   <= '0;
            r_tok   <= '0;
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= is_result;
            unique case (i_ctrl.kind)
                K2_ADV: begin
                    if (i_acc != '0) begin
                        r_match <= 1'b1;
                        r_len   <= i_pos;
                        r_tok   <= i_acc;
                    end
                end
                K2_END, K2_QUIET: begin
                    r_match <= 1'b0;
                    r_len   <= '0;
                    r_tok   <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && is_result) begin
            r_data.longest_found <= r_match;
            r_data.token_length  <= 16'(r_len);
            r_data.match_id      <= 16'(r_tok);
            r_data.full_match    <= (i_ctrl.kind == K2_END) && i_ctrl.full;
            r_data.dead_end      <= (i_ctrl.kind == K2_DEAD);
        end
    end

    assign o_res.valid = r_valid;
    assign o_res.data  = r_data;
endmodule

[tb/dfa_longest_match_scanner_core_tb.sv]
// Self-checking testbench for the DFA longest-match scanner core.
// Depends on dlms_pkg, dlms_chan_if and the scanner core with its submodules.
module dfa_longest_match_scanner_core_tb;
    import dlms_pkg::*;

    localparam int          N_STATES       = 64;
    localparam int          N_CHARS        = 128;
    localparam logic [15:0] LEN_SAT        = 16'hFFFF;
    // Long enough to cover the quiet clearing pass after reset
    localparam int          WATCHDOG_LIMIT = 40000;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          DRAIN_LIMIT    = 5000;
    localparam int          TAIL_CYCLES    = 10;
    // Random automata live in a few low states over a small pool of characters
    localparam int          DFA_STATES     = 8;
    localparam int          POOL_SIZE      = 6;
    localparam int          LOOP_CHARS     = 20;
    localparam int          RANDOM_ITEMS   = 320;
    localparam int          EXP_DEPTH      = 64;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dlms_chan_if #(.t_payload(t_in_item))  in_ch ();
    dlms_chan_if #(.t_payload(t_res_item)) res_ch ();

    dfa_longest_match_scanner_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_res   (res_ch)
    );

    always #10 i_clk = ~i_clk;

    // Predicted copy of the scanner: the three stores and the scan registers
    logic [6:0]  trans_tab  [N_STATES*N_CHARS];
    logic [15:0] accept_tab [N_STATES*N_STATES];
    logic        final_tab  [N_STATES];
    logic [5:0]  cur_state;
    logic [15:0] pos_cnt;
    logic [15:0] best_len;
    logic [15:0] best_tok;
    logic        hit_seen;
    logic        stopped;

    // Predicted results waiting for the core, oldest at exp_rd
    t_res_item   exp_res [EXP_DEPTH];
    int          exp_wr = 0;
    int          exp_rd = 0;
    logic [6:0]  char_pool [POOL_SIZE];

    int err_cnt        = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;
    bit hold_req       = 1'b0;

    function automatic void restart_scan_model();
        cur_state = '0;
        pos_cnt   = '0;
        best_len  = '0;
        best_tok  = '0;
        hit_seen  = 1'b0;
        stopped   = 1'b0;
    endfunction

    function automatic t_res_item scan_summary(input logic full, input logic dead);
        t_res_item res;
        res.longest_found = hit_seen;
        res.token_length  = best_len;
        res.match_id      = best_tok;
        res.full_match    = full;
        res.dead_end      = dead;
        return res;
    endfunction

    function automatic void queue_result(input t_res_item res);
        if (exp_wr - exp_rd >= EXP_DEPTH) begin
            $display("%0t: prediction buffer overflow, expected room, got %0d waiting",
                     $time, exp_wr - exp_rd);
            err_cnt++;
        end
        exp_res[exp_wr % EXP_DEPTH] = res;
        exp_wr++;
    endfunction

    // Apply one accepted transaction to the predicted state and queue the
    // result it gives, if any
    function automatic void predict_scan_result(input t_in_item it);
        logic [6:0]  nxt;
        logic [5:0]  tgt;
        logic [15:0] acc;
        case (it.func)
            FUNC_WR_TRANS:  trans_tab[{it.row_state, it.char_code}] = it.next_entry;
            FUNC_WR_ACCEPT: accept_tab[{it.row_state, it.col_state}] = it.token_value;
            FUNC_WR_FINAL:  final_tab[it.row_state] = it.final_flag;
            FUNC_CHAR: begin
                if (!stopped) begin
                    nxt = trans_tab[{cur_state, it.char_code}];
                    if (nxt == 7'd0 || nxt > 7'(N_STATES)) begin
                        queue_result(scan_summary(1'b0, 1'b1));
                        stopped = 1'b1;
                    end else begin
                        tgt = 6'(nxt - 7'd1);
                        acc = accept_tab[{cur_state, tgt}];
                        if (acc != 16'd0) begin
                            hit_seen = 1'b1;
                            best_len = (pos_cnt == LEN_SAT) ? LEN_SAT : pos_cnt + 16'd1;
                            best_tok = acc;
                        end
                        cur_state = tgt;
                        if (pos_cnt != LEN_SAT) pos_cnt = pos_cnt + 16'd1;
                    end
                end
            end
            FUNC_END: begin
                // After a dead end the end item only restarts the scan
                if (!stopped) queue_result(scan_summary(final_tab[cur_state], 1'b0));
                restart_scan_model();
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            err_cnt++;
        end
    endfunction

    // Compare every result transaction with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_res_item want;
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            if (exp_wr == exp_rd) begin
                $display("%0t: unexpected result, expected none, got %p", $time, res_ch.data);
                err_cnt++;
            end else begin
                want = exp_res[exp_rd % EXP_DEPTH];
                exp_rd++;
                check_field("longest_found", 16'(want.longest_found),
                            16'(res_ch.data.longest_found));
                check_field("token_length", want.token_length, res_ch.data.token_length);
                check_field("match_id", want.match_id, res_ch.data.match_id);
                check_field("full_match", 16'(want.full_match), 16'(res_ch.data.full_match));
                check_field("dead_end", 16'(want.dead_end), 16'(res_ch.data.dead_end));
            end
        end
    end

    // Receiver: stall at random, or hold off for a long stretch on request
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                res_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: count cycles with no transaction on either channel
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("simulation failed");
            $finish;
        end
    end

    // Offer one transaction, after a random gap, and hold it until accepted.
    // Leave valid high afterwards so back-to-back items need no second
    // assignment in the same step.
    task automatic send_item(input t_in_item it);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= it;
        do @(posedge i_clk); while (in_ch.ready !== 1'b1);
        predict_scan_result(it);
    endtask

    function automatic t_in_item rand_item();
        t_in_item it;
        it.func        = 3'($urandom_range(7));
        it.row_state   = 6'($urandom_range(63));
        it.char_code   = 7'($urandom_range(127));
        it.next_entry  = 7'($urandom_range(127));
        it.col_state   = 6'($urandom_range(63));
        it.token_value = 16'($urandom_range(16'hFFFF));
        it.final_flag  = 1'($urandom_range(1));
        return it;
    endfunction

    // Unused fields stay random so that the block is seen to ignore them
    task automatic wr_trans(input int row, input int ch, input int entry);
        t_in_item it;
        it = rand_item();
        it.func       = FUNC_WR_TRANS;
        it.row_state  = 6'(row);
        it.char_code  = 7'(ch);
        it.next_entry = 7'(entry);
        send_item(it);
    endtask

    task automatic wr_accept(input int row, input int col, input int tok);
        t_in_item it;
        it = rand_item();
        it.func        = FUNC_WR_ACCEPT;
        it.row_state   = 6'(row);
        it.col_state   = 6'(col);
        it.token_value = 16'(tok);
        send_item(it);
    endtask

    task automatic wr_final(input int row, input int flag);
        t_in_item it;
        it = rand_item();
        it.func       = FUNC_WR_FINAL;
        it.row_state  = 6'(row);
        it.final_flag = 1'(flag);
        send_item(it);
    endtask

    task automatic scan_char(input int ch);
        t_in_item it;
        it = rand_item();
        it.func      = FUNC_CHAR;
        it.char_code = 7'(ch);
        send_item(it);
    endtask

    task automatic scan_end();
        t_in_item it;
        it = rand_item();
        it.func = FUNC_END;
        send_item(it);
    endtask

    task automatic send_func(input logic [2:0] code);
        t_in_item it;
        it = rand_item();
        it.func = code;
        send_item(it);
    endtask

    // Load a random automaton over the low states and a fresh character pool
    task automatic load_random_dfa();
        int r;
        int entry;
        for (int k = 0; k < POOL_SIZE; k++) char_pool[k] = 7'($urandom_range(127));
        for (int s = 0; s < DFA_STATES; s++) begin
            for (int k = 0; k < POOL_SIZE; k++) begin
                r = $urandom_range(99);
                if (r < 70)      entry = $urandom_range(DFA_STATES, 1);
                else if (r < 78) entry = $urandom_range(127, N_STATES + 1);
                else             entry = 0;
                wr_trans(s, char_pool[k], entry);
            end
            repeat (3) begin
                r = $urandom_range(99);
                wr_accept(s, $urandom_range(DFA_STATES - 1),
                          (r < 20) ? 0 : $urandom_range(16'hFFFF, 1));
            end
            wr_final(s, $urandom_range(1));
        end
    endtask

    // One random transaction: mostly characters that follow a live
    // transition, with ends, table writes mid-scan and raw noise mixed in
    task automatic gen_random_item();
        t_in_item   it;
        int         r;
        int         start;
        logic [6:0] ch;
        logic [6:0] nxt;
        it = rand_item();
        r  = $urandom_range(99);
        if (r < 8) begin
            // raw noise: any code, unused ones included
        end else if (stopped) begin
            it.func = ($urandom_range(99) < 70) ? FUNC_END : FUNC_CHAR;
        end else if (r < 14) begin
            it.func       = 3'($urandom_range(2));
            it.row_state  = 6'($urandom_range(DFA_STATES - 1));
            it.char_code  = char_pool[$urandom_range(POOL_SIZE - 1)];
            it.next_entry = 7'($urandom_range(DFA_STATES + 1));
            it.col_state  = 6'($urandom_range(DFA_STATES - 1));
        end else if (r < 24) begin
            it.func = FUNC_END;
        end else begin
            it.func      = FUNC_CHAR;
            it.char_code = char_pool[$urandom_range(POOL_SIZE - 1)];
            if ($urandom_range(99) < 85) begin
                start = $urandom_range(POOL_SIZE - 1);
                for (int k = 0; k < POOL_SIZE; k++) begin
                    ch  = char_pool[(start + k) % POOL_SIZE];
                    nxt = trans_tab[{cur_state, ch}];
                    if (nxt != 7'd0 && nxt <= 7'(N_STATES)) it.char_code = ch;
                end
            end
        end
        send_item(it);
    endtask

    // Two accepting transitions in a row: the later, longer one wins
    task automatic test_longest_match();
        wr_trans(0, 97, 2);
        wr_trans(1, 98, 3);
        wr_accept(0, 1, 16'hFFFF);
        wr_accept(1, 2, 16'h0001);
        wr_final(2, 1);
        scan_char(97);
        scan_char(98);
        scan_end();
    endtask

    // Dead end reports at once; ignore characters until the end item,
    // which gives no second result; then an empty scan
    task automatic test_dead_end();
        scan_char(97);
        scan_char(99);
        scan_char(97);
        scan_end();
        scan_end();
    endtask

    // Extreme characters and entries: last state, and entries past the states
    task automatic test_table_limits();
        wr_trans(0, 127, N_STATES);
        wr_accept(0, 63, 16'h8000);
        wr_trans(63, 0, N_STATES + 1);
        wr_final(63, 1);
        scan_char(127);
        scan_end();
        scan_char(127);
        scan_char(0);
        scan_end();
        wr_trans(0, 0, 127);
        scan_char(0);
        scan_end();
    endtask

    // Unused codes in the middle of a scan, and a table write that must
    // affect the very next character
    task automatic test_write_mid_scan();
        scan_char(97);
        send_func(3'd5);
        send_func(3'd6);
        send_func(3'd7);
        wr_trans(1, 99, 1);
        scan_char(99);
        wr_final(0, 1);
        scan_end();
    endtask

    // Run a stream of characters round an accepting self-loop back to back
    task automatic test_accepting_loop();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wr_trans(0, 120, 1);
        wr_accept(0, 0, 16'h1234);
        repeat (LOOP_CHARS) scan_char(120);
        scan_end();
    endtask

    task automatic test_random_phase(input int send_pct, input int recv_pct, input int n);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        load_random_dfa();
        repeat (n) gen_random_item();
    endtask

    // Hold the receiver off while the sender keeps offering, so the core
    // fills up and stalls its input
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_req       = 1'b1;
        repeat (200) gen_random_item();
    endtask

    initial begin : main
        int guard;
        foreach (trans_tab[i])  trans_tab[i]  = '0;
        foreach (accept_tab[i]) accept_tab[i] = '0;
        foreach (final_tab[i])  final_tab[i]  = 1'b0;
        restart_scan_model();
        in_ch.valid = 1'b0;
        in_ch.data  = '0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct  = 29;
        recv_stall_pct = 29;
        test_longest_match();
        test_dead_end();
        test_table_limits();
        test_write_mid_scan();
        test_accepting_loop();
        test_random_phase(0, 0, RANDOM_ITEMS);
        test_random_phase(75, 0, RANDOM_ITEMS);
        test_random_phase(0, 75, RANDOM_ITEMS);
        test_random_phase(29, 29, RANDOM_ITEMS);
        test_backpressure();

        in_ch.valid <= 1'b0;
        guard = 0;
        while (exp_wr != exp_rd && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (exp_wr != exp_rd)
            $display("%0t: %0d results never arrived", $time, exp_wr - exp_rd);
        if (err_cnt == 0 && exp_wr == exp_rd)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[files.f]
src/dlms_pkg.sv
src/dlms_chan_if.sv
src/dlms_ram.sv
src/dlms_match_track.sv
src/dfa_longest_match_scanner_core.sv
tb/dfa_longest_match_scanner_core_tb.sv
